>>> rtl/core/seven_segment_four_digit_scanner_top_defines.svh
// Assertion macros used by the seven-segment scanner core.
`ifndef SEVEN_SEGMENT_FOUR_DIGIT_SCANNER_TOP_DEFINES_SVH
`define SEVEN_SEGMENT_FOUR_DIGIT_SCANNER_TOP_DEFINES_SVH

// Checks a consequent in the same cycle as its antecedent.
`define SSFDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks a consequent in the cycle after its antecedent.
`define SSFDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ssfds_pkg.sv
// Package with types, codes and display tables of the seven-segment scanner.
`default_nettype none
package ssfds_pkg;

  localparam int MODE_W = 3;
  localparam int NUM_W  = 16;
  localparam int CODE_W = 4;
  localparam int SEG_W  = 8;
  localparam int SEL_W  = 4;
  localparam int DEC_W  = 14;

  typedef logic [CODE_W-1:0] digit_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 3'd0,
    MODE_LOAD  = 3'd1,
    MODE_SHL   = 3'd2,
    MODE_SHR   = 3'd3,
    MODE_WR0   = 3'd4,
    MODE_WRALL = 3'd5
  } mode_t;

  // One registered item: mode, the number already split into digits, and the codes.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    digit_t [3:0]      load_digits;
    digit_t [3:0]      codes;
  } item_t;

  localparam logic [SEG_W-1:0] SEG_TABLE [16] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
    8'h80, 8'h90, 8'hBF, 8'hC7, 8'hA3, 8'h89, 8'hEF, 8'hFF
  };

  localparam logic [SEL_W-1:0] SEL_TABLE [4] = '{4'h7, 4'hB, 4'hD, 4'hE};

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;
  localparam logic [SEL_W-1:0] SEL_NONE  = 4'hF;

endpackage
`default_nettype wire

>>> rtl/core/ssfds_in_if.sv
// Input channel interface of the seven-segment scanner.
`default_nettype none
interface ssfds_in_if;
  import ssfds_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [NUM_W-1:0]  number;
  logic [CODE_W-1:0] code_d3;
  logic [CODE_W-1:0] code_d2;
  logic [CODE_W-1:0] code_d1;
  logic [CODE_W-1:0] code_d0;

  modport source (output valid, mode, number, code_d3, code_d2, code_d1, code_d0,
                  input ready);
  modport sink   (input valid, mode, number, code_d3, code_d2, code_d1, code_d0,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/core/ssfds_out_if.sv
// Result channel interface of the seven-segment scanner.
`default_nettype none
interface ssfds_out_if;
  import ssfds_pkg::*;

  logic              valid;
  logic              ready;
  logic [SEG_W-1:0]  segments;
  logic [SEL_W-1:0]  digit_select;
  logic [DEC_W-1:0]  decimal_value;

  modport source (output valid, segments, digit_select, decimal_value, input ready);
  modport sink   (input valid, segments, digit_select, decimal_value, output ready);
endinterface
`default_nettype wire

>>> rtl/core/seven_segment_four_digit_scanner_top.sv
// Top level of the multiplexed four-digit seven-segment scanner.
// The scanner takes one item in every cycle while the result channel is ready
// and returns one result for each item: the input stage registers the item
// together with its number already split into four decimal digits by
// reciprocal multiplies, and the core updates the digit buffer and scan state
// and registers the result. A tick advances the scan index and drives the
// active-low segments and one-cold digit select, which hold until the next
// tick; every result also carries the buffer read as a decimal number.
`default_nettype none
module seven_segment_four_digit_scanner_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ssfds_in_if.sink    in_ch,
  ssfds_out_if.source out_ch
);
  import ssfds_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_take;

  ssfds_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take)
  );

  ssfds_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .out_ch     (out_ch)
  );
endmodule
`default_nettype wire

>>> rtl/core/ssfds_in_stage.sv
// Input register of the scanner, which also splits the number into decimal digits.
`default_nettype none
module ssfds_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  ssfds_in_if.sink            in_ch,
  output ssfds_pkg::item_t    item,
  output logic                item_valid,
  input  wire logic           item_take
);
  import ssfds_pkg::*;

  item_t       item_r;
  logic        valid_r;
  logic        valid_nxt;
  logic        accept;
  logic [32:0] prod10;
  logic [32:0] prod100;
  logic [32:0] prod1000;
  logic [12:0] quot10;
  logic [9:0]  quot100;
  logic [6:0]  quot1000;
  digit_t [3:0] split;

  // Remainder by ten of a value below 100.
  function automatic digit_t mod10_small(input logic [6:0] q);
    logic [6:0] r;
    if (q >= 7'd90) r = q - 7'd90;
    else if (q >= 7'd80) r = q - 7'd80;
    else if (q >= 7'd70) r = q - 7'd70;
    else if (q >= 7'd60) r = q - 7'd60;
    else if (q >= 7'd50) r = q - 7'd50;
    else if (q >= 7'd40) r = q - 7'd40;
    else if (q >= 7'd30) r = q - 7'd30;
    else if (q >= 7'd20) r = q - 7'd20;
    else if (q >= 7'd10) r = q - 7'd10;
    else r = q;
    return r[CODE_W-1:0];
  endfunction

  // The quotients come from reciprocal multiplies that are exact over 16 bits.
  always_comb begin
    prod10   = 33'(in_ch.number) * 33'd52429;
    prod100  = 33'(in_ch.number) * 33'd83887;
    prod1000 = 33'(in_ch.number) * 33'd67109;
    quot10   = prod10[31:19];
    quot100  = prod100[32:23];
    quot1000 = prod1000[32:26];
    split[0] = CODE_W'(in_ch.number - {quot10[11:0], 3'b000} - {quot10, 1'b0} - 16'd0);
    split[1] = CODE_W'(quot10 - {quot100, 3'b000} - {2'b00, quot100, 1'b0});
    split[2] = CODE_W'(quot100 - {quot1000[6:0], 3'b000} - {2'b00, quot1000, 1'b0});
    split[3] = mod10_small(quot1000);
  end

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !valid_r || item_take;
  assign item        = item_r;
  assign item_valid  = valid_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.mode        <= in_ch.mode;
      item_r.load_digits <= split;
      item_r.codes       <= {in_ch.code_d3, in_ch.code_d2, in_ch.code_d1, in_ch.code_d0};
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/ssfds_core.sv
// Digit buffer, scan state and result register of the seven-segment scanner.
`default_nettype none
`include "seven_segment_four_digit_scanner_top_defines.svh"
module ssfds_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ssfds_pkg::item_t item,
  input  wire logic             item_valid,
  output logic                  item_take,
  ssfds_out_if.source           out_ch
);
  import ssfds_pkg::*;

  digit_t [3:0]     digit_r;
  digit_t [3:0]     digit_nxt;
  logic [1:0]       scan_r;
  logic [1:0]       scan_nxt;
  logic [SEG_W-1:0] seg_r;
  logic [SEG_W-1:0] seg_nxt;
  logic [SEL_W-1:0] sel_r;
  logic [SEL_W-1:0] sel_nxt;
  logic [DEC_W-1:0] dec_r;
  logic [DEC_W-1:0] dec_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;

  // Reads the buffer as decimal from the leftmost digit, skipping non-decimal codes.
  function automatic logic [DEC_W-1:0] buffer_value(input digit_t [3:0] d);
    logic [DEC_W-1:0] v;
    v = '0;
    for (int k = 3; k >= 0; k--) begin
      if (d[k] <= digit_t'(9)) begin
        v = DEC_W'({v, 3'b000}) + DEC_W'({v, 1'b0}) + DEC_W'(d[k]);
      end
    end
    return v;
  endfunction

  assign item_take = item_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    digit_nxt = digit_r;
    scan_nxt  = scan_r;
    seg_nxt   = seg_r;
    sel_nxt   = sel_r;
    case (mode_t'(item.mode))
      MODE_TICK: begin
        scan_nxt = scan_r + 2'd1;
        seg_nxt  = SEG_TABLE[digit_r[scan_nxt]];
        sel_nxt  = SEL_TABLE[scan_nxt];
      end
      MODE_LOAD: begin
        digit_nxt = item.load_digits;
      end
      MODE_SHL: begin
        digit_nxt = {digit_r[2:0], digit_t'(0)};
      end
      MODE_SHR: begin
        digit_nxt = {digit_t'(0), digit_r[3:1]};
      end
      MODE_WR0: begin
        digit_nxt[0] = item.codes[0];
      end
      MODE_WRALL: begin
        digit_nxt = item.codes;
      end
      default: begin
      end
    endcase
    dec_nxt = buffer_value(digit_nxt);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (item_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r     <= '0;
      scan_r      <= 2'd0;
      seg_r       <= SEG_BLANK;
      sel_r       <= SEL_NONE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (item_take) begin
        digit_r <= digit_nxt;
        scan_r  <= scan_nxt;
        seg_r   <= seg_nxt;
        sel_r   <= sel_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      dec_r <= dec_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.segments      = seg_r;
  assign out_ch.digit_select  = sel_r;
  assign out_ch.decimal_value = dec_r;

  `SSFDS_ASSERT_NOW(a_sel_one_cold, sel_r != SEL_NONE, $onehot(~sel_r), "select not one-cold")
  `SSFDS_ASSERT_NOW(a_dec_range, out_valid_r, dec_r <= 14'd9999, "decimal value out of range")
  `SSFDS_ASSERT_NEXT(a_digits_hold, !item_take, $stable(digit_r), "digits changed without item")
  `SSFDS_ASSERT_NEXT(a_seg_hold, !(item_take && item.mode == MODE_TICK), $stable(seg_r), "segments changed without tick")
endmodule
`default_nettype wire
